// ----- rtl/bpc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the barometric compensation block
// no dependencies; used through scoped names by every rtl file but bpc_checker

package bpc_pkg;

    // configuration port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int COEF_W  = 16;

    // field widths
    localparam int ADC_W   = 24;
    localparam int PRESS_W = 20;
    localparam int TEMP_W  = 19;

    // datapath widths
    localparam int OPND_W  = 26;          // multiplier operand, signed
    localparam int PROD_W  = 2 * OPND_W;  // registered product
    localparam int CORR_W  = 40;          // offset and sensitivity
    localparam int TINT_W  = 20;          // internal temperature
    localparam int ACC_W   = 64;          // pressure product accumulator
    localparam int DIFF_W  = 45;          // scaled product minus offset
    localparam int T2_W    = 18;          // dT squared term

    // temperature thresholds in hundredths of a degree
    localparam logic signed [TINT_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TINT_W-1:0] TEMP_COLD = -20'sd1500;
    localparam logic signed [TINT_W-1:0] TEMP_MIN  = -20'sd262144;
    localparam logic signed [TINT_W-1:0] TEMP_MAX  = 20'sd262143;

    // register indexes
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } reg_idx_t;

    // calibration coefficients
    typedef struct packed {
        logic [COEF_W-1:0] c6;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c1;
    } coef_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_M9,
        ST_M10,
        ST_FIN,
        ST_DONE
    } ctrl_state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DT,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_M4,
        OP_M5,
        OP_M6,
        OP_M7,
        OP_M8,
        OP_M9,
        OP_M10,
        OP_FIN
    } dp_op_t;

    // command from controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

endpackage

// ----- rtl/bpc_regs.sv -----
`timescale 1ns / 1ps
// apb register file holding the six calibration coefficients
// depends on bpc_pkg

module bpc_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bpc_pkg::coef_t               coef
);

    bpc_pkg::coef_t   coef_reg;
    bpc_pkg::coef_t   coef_next;
    bpc_pkg::reg_idx_t idx;
    logic             wr_en;
    logic [bpc_pkg::COEF_W-1:0] rd_val;

    assign pready = 1'b1;
    assign idx    = bpc_pkg::reg_idx_t'(paddr[bpc_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign coef   = coef_reg;

    // write decode, out-of-range indexes are dropped
    always_comb begin
        coef_next = coef_reg;
        if (wr_en) begin
            unique case (idx)
                bpc_pkg::REG_C1: coef_next.c1 = pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_C2: coef_next.c2 = pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_C3: coef_next.c3 = pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_C4: coef_next.c4 = pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_C5: coef_next.c5 = pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_C6: coef_next.c6 = pwdata[bpc_pkg::COEF_W-1:0];
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            bpc_pkg::REG_C1: rd_val = coef_reg.c1;
            bpc_pkg::REG_C2: rd_val = coef_reg.c2;
            bpc_pkg::REG_C3: rd_val = coef_reg.c3;
            bpc_pkg::REG_C4: rd_val = coef_reg.c4;
            bpc_pkg::REG_C5: rd_val = coef_reg.c5;
            bpc_pkg::REG_C6: rd_val = coef_reg.c6;
            default:         rd_val = '0;
        endcase
    end

    assign prdata = {{(bpc_pkg::PDATA_W - bpc_pkg::COEF_W){1'b0}}, rd_val};

endmodule

// ----- rtl/bpc_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for the compensation datapath and output handshake
// depends on bpc_pkg

module bpc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output bpc_pkg::dp_cmd_t cmd
);

    bpc_pkg::ctrl_state_t state_reg;
    bpc_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;

    // output slot can take a new result this cycle
    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        unique case (state_reg)
            bpc_pkg::ST_IDLE: state_next = s_tvalid ? bpc_pkg::ST_DT : bpc_pkg::ST_IDLE;
            bpc_pkg::ST_DT:   state_next = bpc_pkg::ST_M1;
            bpc_pkg::ST_M1:   state_next = bpc_pkg::ST_M2;
            bpc_pkg::ST_M2:   state_next = bpc_pkg::ST_M3;
            bpc_pkg::ST_M3:   state_next = bpc_pkg::ST_M4;
            bpc_pkg::ST_M4:   state_next = bpc_pkg::ST_M5;
            bpc_pkg::ST_M5:   state_next = bpc_pkg::ST_M6;
            bpc_pkg::ST_M6:   state_next = bpc_pkg::ST_M7;
            bpc_pkg::ST_M7:   state_next = bpc_pkg::ST_M8;
            bpc_pkg::ST_M8:   state_next = bpc_pkg::ST_M9;
            bpc_pkg::ST_M9:   state_next = bpc_pkg::ST_M10;
            bpc_pkg::ST_M10:  state_next = bpc_pkg::ST_FIN;
            bpc_pkg::ST_FIN:  state_next = bpc_pkg::ST_DONE;
            bpc_pkg::ST_DONE: state_next = out_free ? bpc_pkg::ST_IDLE : bpc_pkg::ST_DONE;
            default:          state_next = bpc_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd.load_out = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            bpc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.op   = s_tvalid ? bpc_pkg::OP_LOAD : bpc_pkg::OP_NONE;
            end
            bpc_pkg::ST_DT:   cmd.op = bpc_pkg::OP_DT;
            bpc_pkg::ST_M1:   cmd.op = bpc_pkg::OP_M1;
            bpc_pkg::ST_M2:   cmd.op = bpc_pkg::OP_M2;
            bpc_pkg::ST_M3:   cmd.op = bpc_pkg::OP_M3;
            bpc_pkg::ST_M4:   cmd.op = bpc_pkg::OP_M4;
            bpc_pkg::ST_M5:   cmd.op = bpc_pkg::OP_M5;
            bpc_pkg::ST_M6:   cmd.op = bpc_pkg::OP_M6;
            bpc_pkg::ST_M7:   cmd.op = bpc_pkg::OP_M7;
            bpc_pkg::ST_M8:   cmd.op = bpc_pkg::OP_M8;
            bpc_pkg::ST_M9:   cmd.op = bpc_pkg::OP_M9;
            bpc_pkg::ST_M10:  cmd.op = bpc_pkg::OP_M10;
            bpc_pkg::ST_FIN:  cmd.op = bpc_pkg::OP_FIN;
            bpc_pkg::ST_DONE: begin
                cmd.op       = bpc_pkg::OP_NONE;
                cmd.load_out = out_free;
            end
            default:          cmd.op = bpc_pkg::OP_NONE;
        endcase
    end

    // output valid flag
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/bpc_dp.sv -----
`timescale 1ns / 1ps
// compensation datapath: one shared 26x26 signed multiplier plus update logic
// depends on bpc_pkg; driven by bpc_ctrl commands

module bpc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bpc_pkg::dp_cmd_t                    cmd,
    input  bpc_pkg::coef_t                      coef,
    input  logic                                in_func,
    input  logic [bpc_pkg::ADC_W-1:0]           in_adc_word,
    output logic [bpc_pkg::PRESS_W-1:0]         pressure_pa,
    output logic signed [bpc_pkg::TEMP_W-1:0]   temp_centideg
);

    localparam int OW = bpc_pkg::OPND_W;
    localparam int PW = bpc_pkg::PROD_W;
    localparam int CW = bpc_pkg::CORR_W;
    localparam int TW = bpc_pkg::TINT_W;
    localparam int AW = bpc_pkg::ACC_W;
    localparam int XW = bpc_pkg::DIFF_W;

    // kept raw conversions
    logic [bpc_pkg::ADC_W-1:0] praw_reg;
    logic [bpc_pkg::ADC_W-1:0] traw_reg;

    logic signed [OW-1:0] dt_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [CW-1:0] off_reg;
    logic signed [CW-1:0] sens_reg;
    logic signed [TW-1:0] temp_reg;
    logic [bpc_pkg::T2_W-1:0] t2_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [XW-1:0] x_reg;
    logic [bpc_pkg::PRESS_W-1:0]       press_out_reg;
    logic signed [bpc_pkg::TEMP_W-1:0] temp_out_reg;

    logic signed [OW-1:0] mul_a;
    logic signed [OW-1:0] mul_b;
    logic signed [OW-1:0] temp_ref_d;
    logic signed [OW-1:0] temp_cold_d;
    logic signed [PW-1:0] prod_sh7;
    logic signed [PW-1:0] prod_sh8;
    logic signed [PW-1:0] prod_sh23;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] acc_sh21;
    logic [CW-1:0] sq;
    logic [CW-1:0] d5;
    logic [CW-1:0] e7;
    logic [CW-1:0] e11;
    logic          below_ref;
    logic          below_cold;
    logic signed [XW-1:0] p_full;
    logic          p_over;
    logic [bpc_pkg::PRESS_W-1:0]       press_sat;
    logic signed [bpc_pkg::TEMP_W-1:0] temp_sat;

    // temperature offsets used as squaring operands
    assign temp_ref_d  = {{(OW-TW){temp_reg[TW-1]}}, temp_reg}
                         - {{(OW-TW){bpc_pkg::TEMP_REF[TW-1]}}, bpc_pkg::TEMP_REF};
    assign temp_cold_d = {{(OW-TW){temp_reg[TW-1]}}, temp_reg}
                         - {{(OW-TW){bpc_pkg::TEMP_COLD[TW-1]}}, bpc_pkg::TEMP_COLD};

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            bpc_pkg::OP_M1: begin
                mul_a = dt_reg;
                mul_b = {{(OW-bpc_pkg::COEF_W){1'b0}}, coef.c4};
            end
            bpc_pkg::OP_M2: begin
                mul_a = dt_reg;
                mul_b = {{(OW-bpc_pkg::COEF_W){1'b0}}, coef.c3};
            end
            bpc_pkg::OP_M3: begin
                mul_a = dt_reg;
                mul_b = {{(OW-bpc_pkg::COEF_W){1'b0}}, coef.c6};
            end
            bpc_pkg::OP_M4: begin
                mul_a = dt_reg;
                mul_b = dt_reg;
            end
            bpc_pkg::OP_M5: begin
                mul_a = temp_ref_d;
                mul_b = temp_ref_d;
            end
            bpc_pkg::OP_M6: begin
                mul_a = temp_cold_d;
                mul_b = temp_cold_d;
            end
            bpc_pkg::OP_M8: begin
                mul_a = {{(OW-bpc_pkg::ADC_W){1'b0}}, praw_reg};
                mul_b = {{(OW-20){1'b0}}, sens_reg[19:0]};
            end
            bpc_pkg::OP_M9: begin
                mul_a = {{(OW-bpc_pkg::ADC_W){1'b0}}, praw_reg};
                mul_b = {{(OW-(CW-20)){sens_reg[CW-1]}}, sens_reg[CW-1:20]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // scaled views of the product
    assign prod_sh7  = prod_reg >>> 7;
    assign prod_sh8  = prod_reg >>> 8;
    assign prod_sh23 = prod_reg >>> 23;
    assign prod_ext  = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
    assign acc_sh21  = acc_reg >>> 21;

    // second-order terms; squares are non-negative
    assign sq  = prod_reg[CW-1:0];
    assign d5  = sq + {sq[CW-3:0], 2'b00};
    assign e7  = {sq[CW-4:0], 3'b000} - sq;
    assign e11 = {sq[CW-4:0], 3'b000} + {sq[CW-2:0], 1'b0} + sq;

    assign below_ref  = temp_reg < bpc_pkg::TEMP_REF;
    assign below_cold = temp_reg < bpc_pkg::TEMP_COLD;

    // raw value capture, zero words keep the old value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            praw_reg <= '0;
            traw_reg <= '0;
        end else if (cmd.op == bpc_pkg::OP_LOAD && in_adc_word != '0) begin
            if (in_func) begin
                traw_reg <= in_adc_word;
            end else begin
                praw_reg <= in_adc_word;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            bpc_pkg::OP_DT: begin
                dt_reg <= $signed({{(OW-bpc_pkg::ADC_W){1'b0}}, traw_reg})
                          - $signed({{(OW-bpc_pkg::COEF_W-8){1'b0}}, coef.c5, 8'd0});
            end
            bpc_pkg::OP_M2: begin
                off_reg <= $signed({{(CW-bpc_pkg::COEF_W-16){1'b0}}, coef.c2, 16'd0})
                           + prod_sh7[CW-1:0];
            end
            bpc_pkg::OP_M3: begin
                sens_reg <= $signed({{(CW-bpc_pkg::COEF_W-15){1'b0}}, coef.c1, 15'd0})
                            + prod_sh8[CW-1:0];
            end
            bpc_pkg::OP_M4: begin
                temp_reg <= bpc_pkg::TEMP_REF + prod_sh23[TW-1:0];
            end
            bpc_pkg::OP_M5: begin
                t2_reg <= prod_reg[31 + bpc_pkg::T2_W - 1:31];
            end
            bpc_pkg::OP_M6: begin
                if (below_ref) begin
                    off_reg  <= off_reg - {1'b0, d5[CW-1:1]};
                    sens_reg <= sens_reg - {2'b00, d5[CW-1:2]};
                end
            end
            bpc_pkg::OP_M7: begin
                if (below_ref && below_cold) begin
                    off_reg  <= off_reg - e7;
                    sens_reg <= sens_reg - {1'b0, e11[CW-1:1]};
                end
                if (below_ref) begin
                    temp_reg <= temp_reg - {{(TW-bpc_pkg::T2_W){1'b0}}, t2_reg};
                end
            end
            bpc_pkg::OP_M9: begin
                acc_reg <= prod_ext;
            end
            bpc_pkg::OP_M10: begin
                acc_reg <= acc_reg + (prod_ext <<< 20);
            end
            bpc_pkg::OP_FIN: begin
                x_reg <= acc_sh21[XW-1:0] - {{(XW-CW){off_reg[CW-1]}}, off_reg};
            end
            default: begin
                x_reg <= x_reg;
            end
        endcase
    end

    // saturation of both results
    assign p_full = x_reg >>> 15;
    assign p_over = |p_full[XW-2:bpc_pkg::PRESS_W];

    always_comb begin
        if (x_reg[XW-1]) begin
            press_sat = '0;
        end else if (p_over) begin
            press_sat = '1;
        end else begin
            press_sat = p_full[bpc_pkg::PRESS_W-1:0];
        end
    end

    always_comb begin
        if (temp_reg < bpc_pkg::TEMP_MIN) begin
            temp_sat = bpc_pkg::TEMP_MIN[bpc_pkg::TEMP_W-1:0];
        end else if (temp_reg > bpc_pkg::TEMP_MAX) begin
            temp_sat = bpc_pkg::TEMP_MAX[bpc_pkg::TEMP_W-1:0];
        end else begin
            temp_sat = temp_reg[bpc_pkg::TEMP_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            press_out_reg <= press_sat;
            temp_out_reg  <= temp_sat;
        end
    end

    assign pressure_pa   = press_out_reg;
    assign temp_centideg = temp_out_reg;

endmodule

// ----- rtl/baro_pressure_temp_compensation.sv -----
`timescale 1ns / 1ps
// top level of the barometric pressure and temperature compensation block
// depends on bpc_pkg, bpc_regs, bpc_ctrl, bpc_dp

// Each input beat carries one 24-bit conversion word tagged in s_tuser as
// pressure (0) or temperature (1); a zero word leaves the stored raw value
// unchanged, and every beat yields exactly one result beat with pressure in
// pascals (saturated to 0..1048575) and temperature in hundredths of a
// degree. One beat is worked on at a time: after acceptance the sequencer
// steps through the states DT, M1..M10, FIN and DONE, where the result
// register loads, and returns to IDLE before the next beat is taken; the
// eight products take turns on the single shared 26x26 multiplier, each one
// registered. A finished result waits in its own register, so the next beat
// may be accepted while it is still unread; the following result then holds
// in the datapath and the input stalls until the output register frees up.
// Coefficients c1..c6 sit at byte addresses 0x00..0x14; the user must write
// them only while the block is idle, as the block does not enforce it.

module baro_pressure_temp_compensation (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // [23:0] adc_word
    input  logic                         s_tuser,   // [0] func
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // [19:0] pressure_pa,
                                                    // [38:20] temp_centideg, [39] zero
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    bpc_pkg::coef_t   coef;
    bpc_pkg::dp_cmd_t cmd;
    logic [bpc_pkg::PRESS_W-1:0]       pressure_pa;
    logic signed [bpc_pkg::TEMP_W-1:0] temp_centideg;

    // coefficient registers
    bpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // sequencer
    bpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // arithmetic
    bpc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .coef          (coef),
        .in_func       (s_tuser),
        .in_adc_word   (s_tdata),
        .pressure_pa   (pressure_pa),
        .temp_centideg (temp_centideg)
    );

    // result packing
    assign m_tdata = {1'b0, temp_centideg, pressure_pa};

endmodule

// ----- rtl/bpc_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the compensation block, bound to the top level
// depends only on the top-level ports

module bpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its data
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // one beat in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in work");

    // no result can appear right after an accept
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised too early");

    // padding bit of the result stays clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[39])
        else $error("result padding bit set");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for baro_pressure_temp_compensation
// depends on bpc_pkg and the rtl top level; needs no files or arguments

module testbench;

    // conversion kind carried in s_tuser
    localparam bit FUNC_PRESS = 1'b0;
    localparam bit FUNC_TEMP  = 1'b1;

    // register slots past the coefficient bank, writes must be dropped
    localparam int REG_SPARE_A = 6;
    localparam int REG_SPARE_B = 7;

    // second-order thresholds in hundredths of a degree
    localparam longint T_REF  = 2000;
    localparam longint T_COLD = -1500;

    localparam longint PRESS_LIMIT = 1048575;
    localparam longint TEMP_LO     = -262144;
    localparam longint TEMP_HI     = 262143;

    localparam int NUM_SETTINGS      = 8;
    localparam int BEATS_PER_SETTING = 150;
    localparam int HOLD_OFF_CYCLES   = 400;
    localparam int DRAIN_CYCLES      = 20;

    // coefficient set to load before a directed row
    typedef enum logic [1:0] {
        CAL_KEEP,
        CAL_TYPICAL,
        CAL_FULL,
        CAL_ZERO
    } cal_sel_t;

    typedef struct packed {
        logic [bpc_pkg::PRESS_W-1:0]        press;
        logic signed [bpc_pkg::TEMP_W-1:0]  temp;
    } comp_result_t;

    typedef struct packed {
        bit                                 known;
        logic [bpc_pkg::PRESS_W-1:0]        press;
        logic signed [bpc_pkg::TEMP_W-1:0]  temp;
    } typed_value_t;

    typedef struct packed {
        cal_sel_t                           cal;
        bit                                 func;
        logic [bpc_pkg::ADC_W-1:0]          word;
        bit                                 known;
        logic [bpc_pkg::PRESS_W-1:0]        press;
        logic signed [bpc_pkg::TEMP_W-1:0]  temp;
    } directed_row_t;

    localparam bpc_pkg::coef_t TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924,
                                               c3: 16'd23317, c4: 16'd23282,
                                               c5: 16'd33464, c6: 16'd28312};

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata = '0;     // [23:0] adc_word
    logic                          s_tuser = 1'b0;   // [0] func
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [39:0]                   m_tdata;          // [19:0] pressure_pa, [38:20] temp_centideg
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [bpc_pkg::PADDR_W-1:0]   paddr = '0;
    logic [bpc_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [bpc_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // shadow of the block state used by the predictor
    bpc_pkg::coef_t                cal_shadow = '0;
    logic [bpc_pkg::ADC_W-1:0]     raw_press_shadow = '0;
    logic [bpc_pkg::ADC_W-1:0]     raw_temp_shadow = '0;

    comp_result_t         pending_results[$];
    typed_value_t         directed_values[$];
    int                   beats_sent = 0;
    int                   results_seen = 0;
    int                   fail_count = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    int                   rx_hold_cycles = 0;

    // directed rows: known values only where the coefficients are all zero
    directed_row_t directed_rows [23] = '{
        '{CAL_KEEP,    FUNC_PRESS, 24'h000000, 1'b1, 20'd0, 19'sd2000},
        '{CAL_KEEP,    FUNC_TEMP,  24'h000000, 1'b1, 20'd0, 19'sd2000},
        '{CAL_KEEP,    FUNC_PRESS, 24'hFFFFFF, 1'b1, 20'd0, 19'sd2000},
        '{CAL_KEEP,    FUNC_TEMP,  24'hFFFFFF, 1'b1, 20'd0, 19'sd2000},
        '{CAL_KEEP,    FUNC_PRESS, 24'h000001, 1'b1, 20'd0, 19'sd2000},
        '{CAL_KEEP,    FUNC_TEMP,  24'h000001, 1'b1, 20'd0, 19'sd2000},
        '{CAL_TYPICAL, FUNC_PRESS, 24'd9085466, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_TEMP,  24'd8077636, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_PRESS, 24'h000000, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_TEMP,  24'h000000, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_TEMP,  24'd8700000, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_TEMP,  24'd6000000, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_TEMP,  24'h000001, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_PRESS, 24'hFFFFFF, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_PRESS, 24'h000001, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_TEMP,  24'hFFFFFF, 1'b0, 20'd0, 19'sd0},
        '{CAL_FULL,    FUNC_TEMP,  24'h010000, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_PRESS, 24'hFFFFFF, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_TEMP,  24'hFFFFFF, 1'b0, 20'd0, 19'sd0},
        '{CAL_KEEP,    FUNC_PRESS, 24'h000001, 1'b0, 20'd0, 19'sd0},
        '{CAL_ZERO,    FUNC_TEMP,  24'd8077636, 1'b1, 20'd0, 19'sd2000},
        '{CAL_KEEP,    FUNC_PRESS, 24'hAAAAAA, 1'b1, 20'd0, 19'sd2000},
        '{CAL_KEEP,    FUNC_PRESS, 24'h555555, 1'b1, 20'd0, 19'sd2000}
    };

    baro_pressure_temp_compensation dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // updates the raw values and works out the compensated pair
    function automatic comp_result_t compensate(input bit func,
                                                input logic [bpc_pkg::ADC_W-1:0] word);
        longint c1, c2, c3, c4, c5, c6;
        longint dt, off, sens, temp, d, p;
        comp_result_t r;
        if (word != 0) begin
            if (func == FUNC_TEMP)
                raw_temp_shadow = word;
            else
                raw_press_shadow = word;
        end
        c1 = longint'(cal_shadow.c1);
        c2 = longint'(cal_shadow.c2);
        c3 = longint'(cal_shadow.c3);
        c4 = longint'(cal_shadow.c4);
        c5 = longint'(cal_shadow.c5);
        c6 = longint'(cal_shadow.c6);

        // first order
        dt   = longint'(raw_temp_shadow) - c5 * 256;
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        temp = T_REF + ((dt * c6) >>> 23);

        // second order, both tests on the first-order temperature
        if (temp < T_REF) begin
            d = temp - T_REF;
            d = 5 * d * d;
            off  -= d >>> 1;
            sens -= d >>> 2;
            if (temp < T_COLD) begin
                d = temp - T_COLD;
                d = d * d;
                off  -= 7 * d;
                sens -= (11 * d) >>> 1;
            end
            temp -= (dt * dt) >>> 31;
        end

        p = (((longint'(raw_press_shadow) * sens) >>> 21) - off) >>> 15;
        if (p < 0)
            p = 0;
        if (p > PRESS_LIMIT)
            p = PRESS_LIMIT;
        if (temp < TEMP_LO)
            temp = TEMP_LO;
        if (temp > TEMP_HI)
            temp = TEMP_HI;
        r.press = p[bpc_pkg::PRESS_W-1:0];
        r.temp  = temp[bpc_pkg::TEMP_W-1:0];
        return r;
    endfunction

    // conversion word, temperature words often near the reference point
    function automatic logic [bpc_pkg::ADC_W-1:0] pick_word(input bit func);
        int     r;
        longint v;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 11)
            return '1;
        if (r < 14)
            return 24'd1;
        if (func == FUNC_TEMP && r < 60) begin
            v = longint'(cal_shadow.c5) * 256 + longint'($urandom_range(1 << 22)) - (1 << 21);
            if (v < 1)
                v = 1;
            if (v > 24'hFFFFFF)
                v = 24'hFFFFFF;
            return v[bpc_pkg::ADC_W-1:0];
        end
        return 24'($urandom);
    endfunction

    function automatic logic [bpc_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // register write followed by a read back
    task automatic write_reg(input int idx, input logic [bpc_pkg::COEF_W-1:0] value);
        logic [bpc_pkg::PDATA_W-1:0] rd;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bpc_pkg::PADDR_W'(idx * 4);
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx <= int'(bpc_pkg::REG_C6)) begin
            case (idx)
                bpc_pkg::REG_C1: cal_shadow.c1 = value;
                bpc_pkg::REG_C2: cal_shadow.c2 = value;
                bpc_pkg::REG_C3: cal_shadow.c3 = value;
                bpc_pkg::REG_C4: cal_shadow.c4 = value;
                bpc_pkg::REG_C5: cal_shadow.c5 = value;
                default: cal_shadow.c6 = value;
            endcase
            if (rd !== {16'h0, value}) begin
                $error("prdata at 0x%02h: expected 0x%08h, actual 0x%08h", idx * 4,
                       {16'h0, value}, rd);
                fail_count++;
            end
        end
    endtask

    task automatic load_coefs(input bpc_pkg::coef_t c);
        write_reg(bpc_pkg::REG_C1, c.c1);
        write_reg(bpc_pkg::REG_C2, c.c2);
        write_reg(bpc_pkg::REG_C3, c.c3);
        write_reg(bpc_pkg::REG_C4, c.c4);
        write_reg(bpc_pkg::REG_C5, c.c5);
        write_reg(bpc_pkg::REG_C6, c.c6);
    endtask

    // one input beat, with a random gap ahead of it
    task automatic send_beat(input bit func, input logic [bpc_pkg::ADC_W-1:0] word,
                             input bit known, input logic [bpc_pkg::PRESS_W-1:0] press,
                             input logic [bpc_pkg::TEMP_W-1:0] temp);
        directed_values.push_back('{known, press, temp});
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_seen < beats_sent)
            @(posedge aclk);
    endtask

    // result side: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // predict on every input beat, check every result beat
    always @(posedge aclk) begin : result_check
        comp_result_t exp_res;
        typed_value_t typed;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                exp_res = compensate(s_tuser, s_tdata);
                typed = directed_values.pop_front();
                if (typed.known) begin
                    exp_res.press = typed.press;
                    exp_res.temp  = typed.temp;
                end
                pending_results.push_back(exp_res);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result beat 0x%010h with nothing expected", m_tdata);
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (m_tdata[19:0] !== exp_res.press) begin
                        $error("pressure_pa: expected %0d, actual %0d",
                               exp_res.press, m_tdata[19:0]);
                        fail_count++;
                    end
                    if (m_tdata[38:20] !== exp_res.temp) begin
                        $error("temp_centideg: expected %0d, actual %0d",
                               exp_res.temp, $signed(m_tdata[38:20]));
                        fail_count++;
                    end
                    if (m_tdata[39] !== 1'b0) begin
                        $error("tdata pad: expected 0, actual %b", m_tdata[39]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        directed_row_t  row;
        bpc_pkg::coef_t next_cal;
        bit             func;
        int             item_no;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, sender sparse and receiver slow
        tx_idle_pct = 23;
        rx_idle_pct = 74;
        for (int i = 0; i < $size(directed_rows); i++) begin
            row = directed_rows[i];
            if (row.cal != CAL_KEEP) begin
                drain();
                case (row.cal)
                    CAL_TYPICAL: load_coefs(TYPICAL_CAL);
                    CAL_FULL: begin
                        load_coefs('1);
                        write_reg(REG_SPARE_A, 16'h1234);
                        write_reg(REG_SPARE_B, 16'h5678);
                    end
                    default: load_coefs('0);
                endcase
            end
            send_beat(row.func, row.word, row.known, row.press, row.temp);
        end

        // random part, new coefficients for each setting
        item_no = 0;
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain();
            next_cal.c1 = pick_coef();
            next_cal.c2 = pick_coef();
            next_cal.c3 = pick_coef();
            next_cal.c4 = pick_coef();
            next_cal.c5 = pick_coef();
            next_cal.c6 = pick_coef();
            load_coefs(next_cal);
            // long receiver hold-off while beats keep coming
            if (s == 1 || s == 6)
                rx_hold_cycles = HOLD_OFF_CYCLES;
            for (int k = 0; k < BEATS_PER_SETTING; k++) begin
                if (item_no < 400) begin
                    tx_idle_pct = 23;
                    rx_idle_pct = 74;
                end else if (item_no < 800) begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 23;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                func = 1'($urandom_range(1));
                send_beat(func, pick_word(func), 1'b0, '0, '0);
                item_no++;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run time limit
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- baro_pressure_temp_compensation.f -----
rtl/bpc_pkg.sv
rtl/bpc_regs.sv
rtl/bpc_ctrl.sv
rtl/bpc_dp.sv
rtl/baro_pressure_temp_compensation.sv
rtl/bpc_checker.sv
tb/testbench.sv
